// File: rtl/tlvs_pkg.sv
`default_nettype none

package tlvs_pkg;

  // Largest region scanned; longer region_length values are clamped to it.
  localparam int unsigned MAX_HEADER_BYTES = 1024;
  localparam int unsigned POS_W            = 11;
  localparam logic [POS_W-1:0] POS_MAX     = '1;
  localparam logic [POS_W:0]   TAG_HDR_LEN = (POS_W+1)'(4);

  // Configuration register indexes
  localparam logic [1:0] CFG_SEARCH_TYPE   = 2'd0;
  localparam logic [1:0] CFG_REGION_LENGTH = 2'd1;
  localparam logic [1:0] CFG_PADDING_BYTE  = 2'd2;
  localparam logic [1:0] CFG_START_ODD     = 2'd3;

  typedef enum logic [1:0] {
    STATUS_FOUND   = 2'd0,
    STATUS_END     = 2'd1,
    STATUS_NO_ROOM = 2'd2,
    STATUS_OVERRUN = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_SEEK    = 2'd0,
    PH_TYPE_LO = 2'd1,
    PH_TYPE_HI = 2'd2,
    PH_LEN_LO  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [15:0]      search_type;
    logic [10:0]      region_length;
    logic [7:0]       padding_byte;
    logic             start_odd;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] byte_pos;
    logic [POS_W-1:0] tag_pos;
    logic [7:0]       win0;
    logic [7:0]       win1;
    logic [7:0]       win2;
    phase_t           phase;
    logic             done;
  } parse_state_t;

  typedef struct packed {
    status_t          status;
    logic [9:0]       field_length;
    logic [10:0]      data_offset;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/tlvs_step.sv
`default_nettype none

// One byte step of the field parser: next state and an optional result.
module tlvs_step
  import tlvs_pkg::*;
(
  input  wire parse_state_t st,
  input  wire cfg_t         cfg,
  input  wire [7:0]         data_byte,
  input  wire               first_byte,
  output parse_state_t      st_next,
  output logic              res_valid,
  output result_t           res
);

  parse_state_t     cur;
  logic [POS_W-1:0] lim;
  logic [POS_W-1:0] b;
  logic [POS_W-1:0] bp_inc;
  logic             short_region;
  logic             active;
  logic             at_tag;
  logic             noroom_cur;
  logic [POS_W-1:0] tag_pad;
  logic             noroom_pad;
  logic             end_mark;
  logic             pad_step;
  logic [15:0]      len16;
  logic [17:0]      span;
  logic             overrun;
  logic             match;
  logic [POS_W-1:0] tag_skip;
  logic             noroom_skip;
  phase_t           phase_next;

  always_comb begin
    if (first_byte) begin
      cur = '0;
      cur.phase = PH_SEEK;
    end else begin
      cur = st;
    end
  end

  assign lim = (cfg.region_length > POS_W'(MAX_HEADER_BYTES)) ?
               POS_W'(MAX_HEADER_BYTES) : cfg.region_length;

  assign b            = cur.byte_pos;
  assign bp_inc       = (b != POS_MAX) ? b + POS_W'(1) : b;
  assign short_region = first_byte && ({1'b0, lim} < TAG_HDR_LEN);
  assign active       = !cur.done && (b < lim);
  assign at_tag       = (b == cur.tag_pos);
  assign noroom_cur   = ({1'b0, cur.tag_pos} + TAG_HDR_LEN) > {1'b0, lim};

  assign tag_pad      = cur.tag_pos + POS_W'(1);
  assign noroom_pad   = ({1'b0, tag_pad} + TAG_HDR_LEN) > {1'b0, lim};
  assign end_mark     = ({data_byte, cur.win0} == 16'd0);
  assign pad_step     = (cur.win0 == cfg.padding_byte) || (cur.tag_pos[0] ^ cfg.start_odd);

  assign len16        = {data_byte, cur.win2};
  assign span         = 18'(cur.tag_pos) + 18'(TAG_HDR_LEN) + 18'(len16);
  assign overrun      = span > 18'(lim);
  assign match        = ({cur.win1, cur.win0} == cfg.search_type);
  assign tag_skip     = span[POS_W-1:0];
  assign noroom_skip  = ({1'b0, tag_skip} + TAG_HDR_LEN) > {1'b0, lim};

  // Phase sequencing
  always_comb begin
    phase_next = cur.phase;
    if (!short_region && active) begin
      case (cur.phase)
        PH_SEEK:    if (at_tag && !noroom_cur) phase_next = PH_TYPE_LO;
        PH_TYPE_LO: if (!end_mark && !pad_step) phase_next = PH_TYPE_HI;
        PH_TYPE_HI: phase_next = PH_LEN_LO;
        PH_LEN_LO:  if (!overrun && !match) phase_next = PH_SEEK;
        default:    phase_next = PH_SEEK;
      endcase
    end
  end

  // Window, positions and result
  always_comb begin
    st_next            = cur;
    st_next.byte_pos   = bp_inc;
    res_valid          = 1'b0;
    res.status         = STATUS_FOUND;
    res.field_length   = '0;
    res.data_offset    = '0;
    if (short_region) begin
      st_next.byte_pos = cur.byte_pos;
      res_valid        = 1'b1;
      res.status       = STATUS_NO_ROOM;
    end else if (active) begin
      case (cur.phase)
        PH_SEEK: begin
          if (at_tag) begin
            if (noroom_cur) begin
              res_valid  = 1'b1;
              res.status = STATUS_NO_ROOM;
            end else begin
              st_next.win0 = data_byte;
            end
          end
        end
        PH_TYPE_LO: begin
          if (end_mark) begin
            res_valid  = 1'b1;
            res.status = STATUS_END;
          end else if (pad_step) begin
            st_next.tag_pos = tag_pad;
            st_next.win0    = data_byte;
            if (noroom_pad) begin
              res_valid  = 1'b1;
              res.status = STATUS_NO_ROOM;
            end
          end else begin
            st_next.win1 = data_byte;
          end
        end
        PH_TYPE_HI: begin
          st_next.win2 = data_byte;
        end
        PH_LEN_LO: begin
          if (overrun) begin
            res_valid  = 1'b1;
            res.status = STATUS_OVERRUN;
          end else if (match) begin
            res_valid        = 1'b1;
            res.status       = STATUS_FOUND;
            res.field_length = len16[9:0];
            res.data_offset  = cur.tag_pos + POS_W'(4);
          end else begin
            st_next.tag_pos = tag_skip;
            if (noroom_skip) begin
              res_valid  = 1'b1;
              res.status = STATUS_NO_ROOM;
            end
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
    if (res_valid) begin
      st_next.done = 1'b1;
    end
    st_next.phase = phase_next;
  end

endmodule

`default_nettype wire

// File: rtl/tlv_header_field_search_top.sv
// Type-length-value field search over a streamed header region.
//
// Input channel (in_valid/in_ready): one header byte per beat, in address
// order. first_byte marks offset 0 of a new region and restarts the parser.
// Output channel (out_valid/out_ready): at most one result beat per region,
// carrying status, field_length and data_offset.
// Config port (cfg_we/cfg_index/cfg_data): writes the register that cfg_index selects;
// write only while no beat is in flight.
//
// Throughput: one byte per cycle, sustained while no result is stalled. A byte is taken
// into the input register, and the parse step (a few compares and an 18-bit sum) runs
// between that register and the result register, so a result is loaded into the result
// register when its byte advances out of the input register.
// Reset clears the parser to offset 0, empties both registers and loads the
// register defaults (type 1, length 248, padding 0xFF, even start).
// When the receiver stalls, the result holds in its register; one more byte
// waits in the input register and then in_ready drops until the result leaves.
`default_nettype none

module tlv_header_field_search_top
  import tlvs_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  data_byte,
  input  wire         first_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  status,
  output logic [9:0]  field_length,
  output logic [10:0] data_offset,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data
);

  cfg_t         cfg;
  parse_state_t pstate;
  parse_state_t pstate_next;
  logic         stg_valid;
  logic [7:0]   stg_byte;
  logic         stg_first;
  logic         stg_adv;
  logic         res_valid;
  result_t      res;
  result_t      out_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.search_type   <= 16'd1;
      cfg.region_length <= 11'd248;
      cfg.padding_byte  <= 8'hFF;
      cfg.start_odd     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEARCH_TYPE:   cfg.search_type   <= cfg_data;
        CFG_REGION_LENGTH: cfg.region_length <= cfg_data[10:0];
        CFG_PADDING_BYTE:  cfg.padding_byte  <= cfg_data[7:0];
        CFG_START_ODD:     cfg.start_odd     <= cfg_data[0];
        default:           cfg.start_odd     <= cfg.start_odd;
      endcase
    end
  end

  // Advance the input register whenever the result slot is free
  assign stg_adv  = stg_valid && (!out_valid || out_ready);
  assign in_ready = !stg_valid || stg_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte  <= data_byte;
      stg_first <= first_byte;
    end
  end

  tlvs_step u_step (
    .st         (pstate),
    .cfg        (cfg),
    .data_byte  (stg_byte),
    .first_byte (stg_first),
    .st_next    (pstate_next),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Parser state: commit one step per consumed beat; all-zero is offset 0,
  // seeking a tag
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= '0;
    end else if (stg_adv) begin
      pstate <= pstate_next;
    end
  end

  // Result register: drop on handoff, load when a step decides the region
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stg_adv && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv && res_valid) begin
      out_res <= res;
    end
  end

  assign status       = out_res.status;
  assign field_length = out_res.field_length;
  assign data_offset  = out_res.data_offset;

endmodule

`default_nettype wire

// File: rtl/tlvs_check.sv
`default_nettype none

module tlvs_check
  import tlvs_pkg::*;
(
  input wire         clk,
  input wire         rst,
  input wire         out_valid,
  input wire         out_ready,
  input wire  [1:0]  status,
  input wire  [9:0]  field_length,
  input wire  [10:0] data_offset
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(field_length) && $stable(data_offset))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Only a found field carries length and offset
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STATUS_FOUND) |-> field_length == '0 && data_offset == '0)
    else $error("length or offset set on a not-found result");

  // Value bytes of a found field follow its four-byte tag
  a_found_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_FOUND) |->
      data_offset >= 11'd4 && data_offset <= 11'(MAX_HEADER_BYTES))
    else $error("found offset outside the region");

endmodule

bind tlv_header_field_search_top tlvs_check u_tlvs_check (.*);

`default_nettype wire
